/* rtl/rrljs_pkg.sv */
// shared types and constants for the rtp receive statistics block
`timescale 1ns / 1ps

package rrljs_pkg;

    localparam int SEQ_W    = 16;
    localparam int WORD_W   = 32;
    localparam int JIT_W    = 40;
    localparam int JIT_FRAC = 8;
    localparam int FRAC_W   = 8;
    localparam int DIV_W    = 34;
    localparam int CNT_W    = 4;

    // floor(ts / 90) = ((ts >> 1) * TS_MS_MAGIC) >> TS_MS_SHIFT for every 32-bit ts
    localparam logic [WORD_W-1:0] TS_MS_MAGIC = 32'hB60B60B7;
    localparam int                TS_MS_SHIFT = 37;

    localparam logic [CNT_W-1:0] FR_DIV_STEPS = CNT_W'(FRAC_W);
    localparam logic [FRAC_W-1:0] FRAC_MAX   = '1;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic scale;
        logic transit;
        logic mag;
        logic update;
        logic frac;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_sts;

endpackage

/* rtl/rrljs_if.sv */
// request and response channel interfaces
`timescale 1ns / 1ps

interface rrljs_req_if
    import rrljs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] rtp_timestamp;
    logic [WORD_W-1:0] arrival_ms;
    logic              retransmit;

    modport source (output valid, op, seq, rtp_timestamp, arrival_ms, retransmit,
                    input ready);
    modport sink   (input valid, op, seq, rtp_timestamp, arrival_ms, retransmit,
                    output ready);
endinterface

interface rrljs_rsp_if
    import rrljs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              gap_flag;
    logic [SEQ_W-1:0]  gap_first;
    logic [SEQ_W-1:0]  gap_last;
    logic [WORD_W-1:0] extended_highest;
    logic [WORD_W-1:0] jitter;
    logic [FRAC_W-1:0] fraction_lost;
    logic [WORD_W-1:0] cumulative_lost;

    modport source (output valid, gap_flag, gap_first, gap_last, extended_highest,
                    jitter, fraction_lost, cumulative_lost, input ready);
    modport sink   (input valid, gap_flag, gap_first, gap_last, extended_highest,
                    jitter, fraction_lost, cumulative_lost, output ready);
endinterface

/* rtl/rtp_receive_loss_jitter_stats.sv */
// top level of the rtp receive loss and jitter statistics block
//
// i_req carries one request at a time: a packet arrival (op 0) or a report
// query (op 1). Every request gives exactly one response on o_rsp.
// i_cfg_we with i_cfg_wdata writes the loss request enable; write it only
// while no request is in flight.
// A packet steps through the timestamp to ms conversion by reciprocal
// multiplication, then the transit, magnitude, state update and response
// load steps. A report steps through a setup step, 8 serial divider steps
// for the fraction lost, a result step and the response load.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result is held in the datapath
// until the output register is free, and i_req.ready stays low meanwhile.
// Synchronous reset clears all counters, the jitter estimate and the
// sequence state, and sets the loss request enable.
`timescale 1ns / 1ps

module rtp_receive_loss_jitter_stats
    import rrljs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    rrljs_req_if.sink   i_req,
    rrljs_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    rrljs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_op     (i_req.op),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rrljs_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_seq              (i_req.seq),
        .i_rtp_timestamp    (i_req.rtp_timestamp),
        .i_arrival_ms       (i_req.arrival_ms),
        .i_retransmit       (i_req.retransmit),
        .o_gap_flag         (o_rsp.gap_flag),
        .o_gap_first        (o_rsp.gap_first),
        .o_gap_last         (o_rsp.gap_last),
        .o_extended_highest (o_rsp.extended_highest),
        .o_jitter           (o_rsp.jitter),
        .o_fraction_lost    (o_rsp.fraction_lost),
        .o_cumulative_lost  (o_rsp.cumulative_lost)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    a_gap_no_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.gap_flag |-> o_rsp.fraction_lost == '0)
        else $error("packet response carries a fraction lost");

    a_gap_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.gap_flag |-> o_rsp.gap_first != o_rsp.gap_last)
        else $error("gap reported with empty range");

    a_load_on_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_rsp.valid)
        else $error("response load without valid");

endmodule

/* rtl/rrljs_ctrl.sv */
// controller state machine sequencing packet and report requests
`timescale 1ns / 1ps

module rrljs_ctrl
    import rrljs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_op,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PREP    = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_TRANSIT = 4'd3;
    localparam logic [3:0] S_MAG     = 4'd4;
    localparam logic [3:0] S_UPDATE  = 4'd5;
    localparam logic [3:0] S_FRAC    = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;
    localparam logic [3:0] S_SCALE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_op == OP_REPORT) ? S_PREP : S_SCALE;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FRAC;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_TRANSIT;
            end
            S_TRANSIT: begin
                o_cmd.transit = 1'b1;
                n_state       = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_FRAC: begin
                o_cmd.frac = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/rrljs_dp.sv */
// datapath: sequence tracking, timestamp scaling, fraction divider, jitter and loss counters
`timescale 1ns / 1ps

module rrljs_dp
    import rrljs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [SEQ_W-1:0]  i_seq,
    input  logic [WORD_W-1:0] i_rtp_timestamp,
    input  logic [WORD_W-1:0] i_arrival_ms,
    input  logic              i_retransmit,
    output logic              o_gap_flag,
    output logic [SEQ_W-1:0]  o_gap_first,
    output logic [SEQ_W-1:0]  o_gap_last,
    output logic [WORD_W-1:0] o_extended_highest,
    output logic [WORD_W-1:0] o_jitter,
    output logic [FRAC_W-1:0] o_fraction_lost,
    output logic [WORD_W-1:0] o_cumulative_lost
);

    localparam int ACC_W = JIT_W + 5;

    // configuration and captured request
    logic              r_nack;
    logic [SEQ_W-1:0]  r_seq;
    logic [WORD_W-1:0] r_arr;
    logic              r_rtx;

    // statistics state
    logic              r_started;
    logic [SEQ_W-1:0]  r_next_exp;
    logic [SEQ_W-1:0]  r_wrap;
    logic              r_tv;
    logic [WORD_W-1:0] r_last_transit;
    logic [JIT_W-1:0]  r_jitter;
    logic [WORD_W-1:0] r_recv;
    logic [WORD_W-1:0] r_lost;
    logic [WORD_W-1:0] r_recv_rep;
    logic [WORD_W-1:0] r_lost_rep;

    // divider
    logic [DIV_W-1:0]  r_rem;
    logic [WORD_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_dvs;
    logic [WORD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;

    // per request working registers
    logic [WORD_W-1:0] r_transit;
    logic [WORD_W-1:0] r_mag;
    logic              r_tot_zero;
    logic              r_dr_zero;
    logic              r_gap_flag;
    logic [SEQ_W-1:0]  r_gap_first;
    logic [SEQ_W-1:0]  r_gap_last;
    logic [FRAC_W-1:0] r_frac;

    logic [DIV_W:0]    rem_shift;
    logic              rem_ge;
    logic [2*WORD_W-2:0] ms_prod;
    logic [WORD_W-1:0] dl;
    logic [WORD_W-1:0] dr;
    logic [WORD_W:0]   total;
    logic [WORD_W-1:0] diff;
    logic [ACC_W-1:0]  acc;
    logic [SEQ_W-1:0]  ahead;
    logic [SEQ_W-1:0]  highest;

    assign rem_shift = {r_rem, r_dvd[WORD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_dvs};
    assign ms_prod   = r_dvd[WORD_W-1:1] * TS_MS_MAGIC;
    assign dl        = r_lost - r_lost_rep;
    assign dr        = r_recv - r_recv_rep;
    assign total     = {1'b0, dl} + {1'b0, dr};
    assign diff      = r_transit - r_last_transit;
    assign acc       = ({5'b0, r_jitter} << 4) - {5'b0, r_jitter}
                       + ({13'b0, r_mag} << JIT_FRAC);
    assign ahead     = r_seq - r_next_exp;
    assign highest   = r_next_exp - SEQ_W'(1);

    assign o_sts.div_last  = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nack     <= 1'b1;
            r_started  <= 1'b0;
            r_next_exp <= '0;
            r_wrap     <= '0;
            r_tv       <= 1'b0;
            r_last_transit <= '0;
            r_jitter   <= '0;
            r_recv     <= '0;
            r_lost     <= '0;
            r_recv_rep <= '0;
            r_lost_rep <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_nack <= i_cfg_wdata;
            end
            if (i_cmd.prep) begin
                r_cnt <= FR_DIV_STEPS;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.update) begin
                if (!r_tv) begin
                    r_last_transit <= r_transit;
                    r_tv           <= 1'b1;
                end else if (!r_rtx) begin
                    r_jitter       <= acc[JIT_W+3:4];
                    r_last_transit <= r_transit;
                end
                if (!r_rtx) begin
                    r_recv <= r_recv + WORD_W'(1);
                    if (!r_started) begin
                        r_started  <= 1'b1;
                        r_next_exp <= r_seq + SEQ_W'(1);
                    end else if (!ahead[SEQ_W-1]) begin
                        if (r_seq < highest) begin
                            r_wrap <= r_wrap + SEQ_W'(1);
                        end
                        if (r_nack && (ahead != '0)) begin
                            r_lost <= r_lost + WORD_W'(ahead);
                        end
                        r_next_exp <= r_seq + SEQ_W'(1);
                    end
                end
            end
            if (i_cmd.frac) begin
                r_lost_rep <= r_lost;
                r_recv_rep <= r_recv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq      <= i_seq;
            r_arr      <= i_arrival_ms;
            r_rtx      <= i_retransmit && r_nack;
            r_dvd      <= i_rtp_timestamp;
            r_gap_flag <= 1'b0;
            r_gap_first <= '0;
            r_gap_last <= '0;
            r_frac     <= '0;
        end
        if (i_cmd.prep) begin
            r_rem      <= DIV_W'(dl);
            r_dvd      <= '0;
            r_dvs      <= DIV_W'(total);
            r_tot_zero <= (total == '0);
            r_dr_zero  <= (dr == '0);
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? DIV_W'(rem_shift - {1'b0, r_dvs}) : DIV_W'(rem_shift);
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[WORD_W-2:0], rem_ge};
        end
        if (i_cmd.scale) begin
            r_quo <= WORD_W'(ms_prod >> TS_MS_SHIFT);
        end
        if (i_cmd.transit) begin
            r_transit <= r_arr - r_quo;
        end
        if (i_cmd.mag) begin
            r_mag <= diff[WORD_W-1] ? (WORD_W'(0) - diff) : diff;
        end
        if (i_cmd.update && !r_rtx && r_started && !ahead[SEQ_W-1]
                && r_nack && (ahead != '0)) begin
            r_gap_flag  <= 1'b1;
            r_gap_first <= r_next_exp;
            r_gap_last  <= r_seq;
        end
        if (i_cmd.frac) begin
            if (r_tot_zero) begin
                r_frac <= '0;
            end else if (r_dr_zero) begin
                r_frac <= FRAC_MAX;
            end else begin
                r_frac <= r_quo[FRAC_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            o_gap_flag         <= r_gap_flag;
            o_gap_first        <= r_gap_first;
            o_gap_last         <= r_gap_last;
            o_extended_highest <= r_started ? {r_wrap, highest} : '0;
            o_jitter           <= r_jitter[JIT_W-1:JIT_FRAC];
            o_fraction_lost    <= r_frac;
            o_cumulative_lost  <= r_lost;
        end
    end

endmodule

/* tb/rtp_receive_loss_jitter_stats_tb.sv */
// self-checking testbench for the rtp receive loss and jitter statistics block
`timescale 1ns / 1ps

module rtp_receive_loss_jitter_stats_tb;
    import rrljs_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic              gap_flag;
        logic [SEQ_W-1:0]  gap_first;
        logic [SEQ_W-1:0]  gap_last;
        logic [WORD_W-1:0] extended_highest;
        logic [WORD_W-1:0] jitter;
        logic [FRAC_W-1:0] fraction_lost;
        logic [WORD_W-1:0] cumulative_lost;
    } t_stats_rsp;

    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_NACK_OFF,
        ROW_NACK_ON
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              op;
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] ts;
        logic [WORD_W-1:0] arr;
        logic              rtx;
        bit                typed;
        t_stats_rsp        want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    rrljs_req_if req_if();
    rrljs_rsp_if rsp_if();

    rtp_receive_loss_jitter_stats DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    logic              nack_en         = 1'b1;
    logic              st_started      = 1'b0;
    logic [SEQ_W-1:0]  st_next_seq     = '0;
    logic [SEQ_W-1:0]  st_wraps        = '0;
    logic              st_transit_ok   = 1'b0;
    logic [WORD_W-1:0] st_last_transit = '0;
    logic [JIT_W-1:0]  st_jitter_q8    = '0;
    logic [WORD_W-1:0] st_received     = '0;
    logic [WORD_W-1:0] st_lost         = '0;
    logic [WORD_W-1:0] st_received_snap = '0;
    logic [WORD_W-1:0] st_lost_snap    = '0;

    t_stats_rsp stats_expected[$];
    t_stats_rsp rsp_want;
    t_stim_row  directed_rows[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         rx_stall_pct   = 0;
    logic       rx_hold        = 1'b0;
    logic [WORD_W-1:0] strm_ts;
    logic [WORD_W-1:0] strm_arr;
    event       hold_go;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[rtp_receive_loss_jitter_stats] ERROR");
        $finish;
    end

    function automatic t_stats_rsp predict_stats(input logic op, input logic [SEQ_W-1:0] seq,
                                                 input logic [WORD_W-1:0] ts,
                                                 input logic [WORD_W-1:0] arr,
                                                 input logic rtx);
        t_stats_rsp        r;
        logic              is_rtx;
        logic [WORD_W-1:0] transit;
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] dl;
        logic [WORD_W-1:0] dr;
        logic [SEQ_W-1:0]  ahead;
        logic [SEQ_W-1:0]  hi;
        logic [63:0]       acc;
        logic [63:0]       total;
        logic [63:0]       q;
        r = '0;
        is_rtx = rtx & nack_en;
        if (op == OP_PACKET) begin
            transit = arr - ts / 32'd90;
            if (!st_transit_ok) begin
                st_last_transit = transit;
                st_transit_ok = 1'b1;
            end else if (!is_rtx) begin
                diff = transit - st_last_transit;
                mag = diff[31] ? (32'd0 - diff) : diff;
                acc = 64'd15 * {24'd0, st_jitter_q8} + {24'd0, mag, 8'd0};
                st_jitter_q8 = acc[43:4];
                st_last_transit = transit;
            end
            if (!is_rtx) begin
                st_received = st_received + 32'd1;
                if (!st_started) begin
                    st_started = 1'b1;
                    st_next_seq = seq + 16'd1;
                end else begin
                    ahead = seq - st_next_seq;
                    if (ahead < 16'h8000) begin
                        hi = st_next_seq - 16'd1;
                        if (seq < hi) begin
                            st_wraps = st_wraps + 16'd1;
                        end
                        if (nack_en && ahead != 16'd0) begin
                            r.gap_flag = 1'b1;
                            r.gap_first = st_next_seq;
                            r.gap_last = seq;
                            st_lost = st_lost + {16'd0, ahead};
                        end
                        st_next_seq = seq + 16'd1;
                    end
                end
            end
        end else begin
            dl = st_lost - st_lost_snap;
            dr = st_received - st_received_snap;
            total = {32'd0, dl} + {32'd0, dr};
            if (total != 64'd0) begin
                q = {24'd0, dl, 8'd0} / total;
                r.fraction_lost = (q > 64'(FRAC_MAX)) ? FRAC_MAX : q[7:0];
            end
            st_lost_snap = st_lost;
            st_received_snap = st_received;
        end
        hi = st_next_seq - 16'd1;
        r.extended_highest = st_started ? {st_wraps, hi} : '0;
        r.jitter = st_jitter_q8[39:8];
        r.cumulative_lost = st_lost;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (stats_expected.size() == 0) begin
                report_mismatch("response with none pending", 64'd1, 64'd0);
            end else begin
                rsp_want = stats_expected.pop_front();
                if (rsp_if.gap_flag !== rsp_want.gap_flag)
                    report_mismatch("gap_flag", 64'(rsp_if.gap_flag),
                                    64'(rsp_want.gap_flag));
                if (rsp_if.gap_first !== rsp_want.gap_first)
                    report_mismatch("gap_first", 64'(rsp_if.gap_first),
                                    64'(rsp_want.gap_first));
                if (rsp_if.gap_last !== rsp_want.gap_last)
                    report_mismatch("gap_last", 64'(rsp_if.gap_last),
                                    64'(rsp_want.gap_last));
                if (rsp_if.extended_highest !== rsp_want.extended_highest)
                    report_mismatch("extended_highest", 64'(rsp_if.extended_highest),
                                    64'(rsp_want.extended_highest));
                if (rsp_if.jitter !== rsp_want.jitter)
                    report_mismatch("jitter", 64'(rsp_if.jitter), 64'(rsp_want.jitter));
                if (rsp_if.fraction_lost !== rsp_want.fraction_lost)
                    report_mismatch("fraction_lost", 64'(rsp_if.fraction_lost),
                                    64'(rsp_want.fraction_lost));
                if (rsp_if.cumulative_lost !== rsp_want.cumulative_lost)
                    report_mismatch("cumulative_lost", 64'(rsp_if.cumulative_lost),
                                    64'(rsp_want.cumulative_lost));
            end
        end
        rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // long receiver hold-off
    initial begin
        forever begin
            @(hold_go);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic send_request(input logic op, input logic [SEQ_W-1:0] seq,
                                input logic [WORD_W-1:0] ts, input logic [WORD_W-1:0] arr,
                                input logic rtx, input bit typed, input t_stats_rsp want);
        t_stats_rsp pred;
        int         gap;
        req_if.valid         <= 1'b1;
        req_if.op            <= op;
        req_if.seq           <= seq;
        req_if.rtp_timestamp <= ts;
        req_if.arrival_ms    <= arr;
        req_if.retransmit    <= rtx;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pred = predict_stats(op, seq, ts, arr, rtx);
        stats_expected = {stats_expected, (typed ? want : pred)};
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(45, 1);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (stats_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_nack_enable(input logic value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        nack_en = value;
    endtask

    function automatic void add_row(input t_row_kind kind, input logic op,
                                    input logic [SEQ_W-1:0] seq, input logic [WORD_W-1:0] ts,
                                    input logic [WORD_W-1:0] arr, input logic rtx,
                                    input bit typed, input t_stats_rsp want);
        t_stim_row row;
        row.kind  = kind;
        row.op    = op;
        row.seq   = seq;
        row.ts    = ts;
        row.arr   = arr;
        row.rtx   = rtx;
        row.typed = typed;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic run_phase(input logic nack, input int send_pct, input int rx_pct,
                             input int count, input bit with_hold);
        logic              op;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  jump;
        logic [WORD_W-1:0] ts;
        logic [WORD_W-1:0] arr;
        logic [WORD_W-1:0] step;
        logic              rtx;
        int                r;
        int                k;
        write_nack_enable(nack);
        send_idle_pct = send_pct;
        rx_stall_pct <= rx_pct;
        if (with_hold) ->hold_go;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                op  = OP_REPORT;
                seq = SEQ_W'($urandom);
                ts  = $urandom;
                arr = $urandom;
                rtx = 1'($urandom_range(1));
            end else if (r < 25) begin
                op  = OP_PACKET;
                seq = SEQ_W'($urandom);
                ts  = $urandom;
                arr = $urandom;
                rtx = 1'($urandom_range(1));
            end else begin
                op = OP_PACKET;
                k = $urandom_range(99);
                if (k < 65) jump = 16'd0;
                else if (k < 85) jump = SEQ_W'($urandom_range(5, 1));
                else if (k < 92) jump = SEQ_W'($urandom_range(16'h7FFF, 6));
                else jump = 16'h8000 + 16'($urandom_range(16'h7FFF, 0));
                seq  = st_next_seq + jump;
                rtx  = ($urandom_range(99) < 8);
                step = 32'd1800 * $urandom_range(4, 1);
                strm_ts  = strm_ts + step;
                strm_arr = strm_arr + step / 32'd90 + $urandom_range(30, 0) - 32'd15;
                ts  = strm_ts;
                arr = strm_arr;
            end
            send_request(op, seq, ts, arr, rtx, 1'b0, '0);
        end
        req_if.valid <= 1'b0;
    endtask

    initial begin
        t_stats_rsp zero_rsp;
        zero_rsp = '0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = 1'b0;
        req_if.valid         = 1'b0;
        req_if.op            = OP_PACKET;
        req_if.seq           = '0;
        req_if.rtp_timestamp = '0;
        req_if.arrival_ms    = '0;
        req_if.retransmit    = 1'b0;
        rsp_if.ready         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_nack_enable(1'b1);

        // report before any packet, then a retransmit before the first packet
        add_row(ROW_REQUEST, OP_REPORT, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b1, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h1234, 32'h0, 32'd100, 1'b1, 1'b1, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0000, 32'd900, 32'd10, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0005, 32'd1800, 32'd20, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_REPORT, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_REPORT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
                zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0003, 32'd2700, 32'd30, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0002, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0006, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0,
                zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0007, 32'h0, 32'h8000_0000, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0008, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h8008, 32'd90, 32'd1, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0009, 32'd180, 32'd2, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'hFFFF, 32'd270, 32'd3, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0000, 32'd360, 32'd4, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_REPORT, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_NACK_OFF, OP_PACKET, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0005, 32'd450, 32'd9, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0006, 32'd540, 32'd30, 1'b1, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_REPORT, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0006, 32'd630, 32'd31, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_NACK_ON, OP_PACKET, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_PACKET, 16'h0007, 32'd720, 32'd99, 1'b1, 1'b0, zero_rsp);
        add_row(ROW_REQUEST, OP_REPORT, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, zero_rsp);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_NACK_OFF: begin
                    req_if.valid <= 1'b0;
                    write_nack_enable(1'b0);
                end
                ROW_NACK_ON: begin
                    req_if.valid <= 1'b0;
                    write_nack_enable(1'b1);
                end
                default: begin
                    send_request(directed_rows[i].op, directed_rows[i].seq,
                                 directed_rows[i].ts, directed_rows[i].arr,
                                 directed_rows[i].rtx, directed_rows[i].typed,
                                 directed_rows[i].want);
                end
            endcase
        end
        req_if.valid <= 1'b0;

        strm_ts  = $urandom;
        strm_arr = $urandom;
        run_phase(1'b1, 0, 0, 100, 1'b0);
        run_phase(1'b0, 45, 0, 80, 1'b0);
        run_phase(1'b1, 0, 45, 80, 1'b1);
        run_phase(1'b1, 10, 10, 100, 1'b1);
        run_phase(1'b0, 0, 0, 40, 1'b0);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("[rtp_receive_loss_jitter_stats] OK");
        end else begin
            $display("[rtp_receive_loss_jitter_stats] ERROR");
        end
        $finish;
    end

endmodule
